### rtl/urh_pkg.sv
// ----------------------------------------------------------------------------
// urh_pkg
// Types, codes and status bit positions shared by the root-hub port emulation.
// ----------------------------------------------------------------------------
package urh_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int TICK_W        = 16;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [3:0] {
    OP_TICK          = 4'd0,
    OP_HUB_REQ       = 4'd1,
    OP_STATUS_POLL   = 4'd2,
    OP_GADGET_DONE   = 4'd3,
    OP_BUS_SUSPEND   = 4'd4,
    OP_BUS_RESUME    = 4'd5,
    OP_STOP          = 4'd6,
    OP_PLAT_RESUME   = 4'd7,
    OP_PLAT_SUSPEND  = 4'd8
  } urh_op_t;

  typedef enum logic [3:0] {
    REQ_CLR_HUB_FEAT  = 4'd0,
    REQ_CLR_PORT_FEAT = 4'd1,
    REQ_GET_HUB_DESC  = 4'd2,
    REQ_DEV_GET_DESC  = 4'd3,
    REQ_GET_HUB_STAT  = 4'd4,
    REQ_GET_PORT_STAT = 4'd5,
    REQ_SET_HUB_FEAT  = 4'd6,
    REQ_SET_PORT_FEAT = 4'd7,
    REQ_GET_ERR_COUNT = 4'd8,
    REQ_SET_HUB_DEPTH = 4'd9,
    REQ_OTHER         = 4'd10
  } urh_req_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_STALL    = 3'd1,
    ERR_NOACCESS = 3'd2,
    ERR_SHUTDOWN = 3'd3,
    ERR_BUSY     = 3'd4
  } urh_err_t;

  typedef enum logic [1:0] {
    RH_RESET     = 2'd0,
    RH_SUSPENDED = 2'd1,
    RH_RUNNING   = 2'd2
  } urh_rh_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_TICKS  = 2'd0,
    CFG_RESUME_TICKS = 2'd1,
    CFG_GADGET_WAIT  = 2'd2
  } urh_cfg_idx_t;

  localparam logic [4:0] FEAT_SUSPEND    = 5'd2;
  localparam logic [4:0] FEAT_RESET      = 5'd4;
  localparam logic [4:0] FEAT_LINK_STATE = 5'd5;
  localparam logic [4:0] FEAT_POWER      = 5'd8;
  localparam logic [4:0] FEAT_U1_TIMEOUT = 5'd23;
  localparam logic [4:0] FEAT_U2_TIMEOUT = 5'd24;
  localparam logic [4:0] FEAT_BH_RESET   = 5'd28;

  localparam logic [15:0] ROOT_PORT = 16'd1;

  localparam logic [31:0] ST_CONN   = 32'h0000_0001;
  localparam logic [31:0] ST_ENABLE = 32'h0000_0002;
  localparam logic [31:0] ST_SUSP   = 32'h0000_0004;
  localparam logic [31:0] ST_RESET  = 32'h0000_0010;
  localparam logic [31:0] ST_POWER  = 32'h0000_0100;
  localparam logic [31:0] ST_LOW    = 32'h0000_0200;
  localparam logic [31:0] ST_HIGH   = 32'h0000_0400;
  localparam logic [31:0] CH_CONN   = 32'h0001_0000;
  localparam logic [31:0] CH_SUSP   = 32'h0004_0000;
  localparam logic [31:0] CH_RESET  = 32'h0010_0000;
  localparam logic [31:0] CH_MASK   = 32'h001F_0000;

  localparam logic [TICK_W-1:0] RESET_TICKS_DEF  = 16'd50;
  localparam logic [TICK_W-1:0] RESUME_TICKS_DEF = 16'd20;
  localparam logic [TICK_W-1:0] GADGET_WAIT_DEF  = 16'd2000;

  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  req_kind;
    logic [4:0]  feature;
    logic [15:0] port_number;
    logic        kick_refused;
  } urh_item_t;

  typedef struct packed {
    logic [31:0] status_word;
    logic [2:0]  error;
    logic        change_pending;
    logic        gadget_reset_kick;
    logic        root_hub_resume_request;
  } urh_result_t;

  typedef struct packed {
    logic [31:0] stat_word;
    logic [31:0] previous_status;
    logic        link_active;
    logic        resuming;
    urh_rh_t     hub_mode;
    logic        hw_accessible;
    logic        conn_timer_armed;
  } urh_ctl_t;

  typedef struct packed {
    urh_ctl_t ctl;
    logic     kick;
    logic     arm;
  } urh_link_res_t;

  function automatic urh_link_res_t update_link(input urh_ctl_t c, input logic refused);
    urh_link_res_t r;
    logic          la;
    r     = '0;
    r.ctl = c;
    la    = 1'b0;
    if ((r.ctl.stat_word & ST_POWER) == '0) begin
      r.ctl.stat_word = '0;
    end else begin
      r.ctl.stat_word = r.ctl.stat_word | ST_CONN;
      if ((c.previous_status & ST_CONN) == '0) begin
        r.ctl.stat_word = r.ctl.stat_word | CH_CONN;
      end
      if ((r.ctl.stat_word & ST_ENABLE) == '0) begin
        r.ctl.stat_word = r.ctl.stat_word & ~ST_SUSP;
      end else if ((r.ctl.stat_word & ST_SUSP) == '0 && c.hub_mode != RH_SUSPENDED) begin
        la = 1'b1;
      end
    end
    if ((r.ctl.stat_word & ST_ENABLE) == '0 || la) begin
      r.ctl.resuming = 1'b0;
    end
    if ((r.ctl.stat_word & ST_CONN) == '0 || (r.ctl.stat_word & ST_RESET) != '0) begin
      if ((ST_RESET & ~c.previous_status & r.ctl.stat_word) != '0) begin
        r.ctl.stat_word = r.ctl.stat_word | ST_POWER;
        r.kick          = 1'b1;
        if (!refused) begin
          r.arm = 1'b1;
        end else begin
          r.ctl.stat_word = CH_CONN;
        end
      end
    end
    r.ctl.previous_status = r.ctl.stat_word;
    r.ctl.link_active     = la;
    return r;
  endfunction

endpackage

### rtl/urh_in_if.sv
// ----------------------------------------------------------------------------
// urh_in_if
// Request/event channel into the root-hub port: valid/ready plus item fields.
// ----------------------------------------------------------------------------
interface urh_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [3:0]  req_kind;
  logic [4:0]  feature;
  logic [15:0] port_number;
  logic        kick_refused;

  modport source (output valid, op, req_kind, feature, port_number, kick_refused,
                  input ready);
  modport sink (input valid, op, req_kind, feature, port_number, kick_refused,
                output ready);
endinterface

### rtl/urh_out_if.sv
// ----------------------------------------------------------------------------
// urh_out_if
// Result channel out of the root-hub port: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface urh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] status_word;
  logic [2:0]  error;
  logic        change_pending;
  logic        gadget_reset_kick;
  logic        root_hub_resume_request;

  modport source (output valid, status_word, error, change_pending, gadget_reset_kick,
                  root_hub_resume_request, input ready);
  modport sink (input valid, status_word, error, change_pending, gadget_reset_kick,
                root_hub_resume_request, output ready);
endinterface

### rtl/urh_step.sv
// ----------------------------------------------------------------------------
// urh_step
// Next-state and result logic for one item applied to the port state.
// ----------------------------------------------------------------------------
module urh_step
  import urh_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  urh_item_t              item,
  input  urh_ctl_t               ctl,
  input  logic [TIME_BITS-1:0]   deadline,
  input  logic [TIME_BITS-1:0]   time_now,
  input  logic [TIME_BITS-1:0]   conn_deadline,
  input  logic [TICK_W-1:0]      reset_ticks,
  input  logic [TICK_W-1:0]      resume_ticks,
  input  logic [TICK_W-1:0]      gadget_wait_ticks,
  output urh_ctl_t               ctl_nxt,
  output logic [TIME_BITS-1:0]   deadline_nxt,
  output logic [TIME_BITS-1:0]   time_now_nxt,
  output logic [TIME_BITS-1:0]   conn_deadline_nxt,
  output urh_result_t            result
);

  function automatic logic reached(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] when);
    logic [TIME_BITS-1:0] d;
    d = now - when;
    return !d[TIME_BITS-1];
  endfunction

  logic [TIME_BITS-1:0] later_reset;
  logic [TIME_BITS-1:0] later_resume;
  logic [TIME_BITS-1:0] later_gadget;

  assign later_reset  = time_now + TIME_BITS'(reset_ticks);
  assign later_resume = time_now + TIME_BITS'(resume_ticks);
  assign later_gadget = time_now + TIME_BITS'(gadget_wait_ticks);

  always_comb begin
    urh_ctl_t      c;
    urh_link_res_t lr;
    urh_err_t      err;
    logic          resume_req;
    logic          do_link;
    urh_op_t       op_e;
    urh_req_t      kind_e;
    c             = ctl;
    lr            = '0;
    err           = ERR_OK;
    resume_req    = 1'b0;
    do_link       = 1'b0;
    op_e          = urh_op_t'(item.op);
    kind_e        = urh_req_t'(item.req_kind);
    deadline_nxt  = deadline;
    time_now_nxt  = time_now;
    conn_deadline_nxt = conn_deadline;

    case (op_e)
      OP_TICK: begin
        time_now_nxt = time_now + TIME_BITS'(1);
        if (c.conn_timer_armed && reached(time_now + TIME_BITS'(1), conn_deadline)) begin
          c.conn_timer_armed = 1'b0;
          c.stat_word        = CH_CONN;
        end
      end
      OP_HUB_REQ: begin
        if (!c.hw_accessible) begin
          err = ERR_NOACCESS;
        end else begin
          case (kind_e)
            REQ_CLR_HUB_FEAT, REQ_GET_HUB_DESC, REQ_GET_HUB_STAT,
            REQ_GET_ERR_COUNT, REQ_SET_HUB_DEPTH: begin
            end
            REQ_CLR_PORT_FEAT: begin
              if (item.feature == FEAT_SUSPEND) begin
                if ((c.stat_word & ST_SUSP) != '0) begin
                  c.resuming   = 1'b1;
                  deadline_nxt = later_resume;
                end
              end else begin
                c.stat_word = c.stat_word & ~(32'd1 << item.feature);
                do_link     = 1'b1;
              end
            end
            REQ_GET_PORT_STAT: begin
              if (item.port_number != ROOT_PORT) begin
                err = ERR_STALL;
              end
              if (c.resuming && reached(time_now, deadline)) begin
                c.stat_word = (c.stat_word | CH_SUSP) & ~ST_SUSP;
              end
              if ((c.stat_word & ST_RESET) != '0 && reached(time_now, deadline)) begin
                c.stat_word = ((c.stat_word | CH_RESET) & ~ST_RESET) | ST_ENABLE | ST_HIGH;
              end
              do_link = 1'b1;
            end
            REQ_SET_PORT_FEAT: begin
              if (item.feature inside {FEAT_LINK_STATE, FEAT_U1_TIMEOUT, FEAT_U2_TIMEOUT}) begin
              end else if (item.feature == FEAT_SUSPEND) begin
                if (c.link_active) begin
                  c.stat_word = c.stat_word | ST_SUSP;
                  do_link     = 1'b1;
                end
              end else if (item.feature == FEAT_POWER) begin
                c.stat_word = c.stat_word | ST_POWER;
                do_link     = 1'b1;
              end else begin
                if (item.feature inside {FEAT_RESET, FEAT_BH_RESET}) begin
                  c.stat_word  = c.stat_word & ~(ST_ENABLE | ST_LOW | ST_HIGH);
                  deadline_nxt = later_reset;
                end
                if ((c.stat_word & ST_POWER) != '0) begin
                  c.stat_word = c.stat_word | (32'd1 << item.feature);
                  do_link     = 1'b1;
                end
              end
            end
            default: begin
              err = ERR_STALL;
            end
          endcase
        end
      end
      OP_STATUS_POLL: begin
        if (c.hw_accessible) begin
          if (c.resuming && reached(time_now, deadline)) begin
            c.stat_word = (c.stat_word | CH_SUSP) & ~ST_SUSP;
            do_link     = 1'b1;
          end
        end
      end
      OP_GADGET_DONE: begin
        c.conn_timer_armed = 1'b0;
      end
      OP_BUS_SUSPEND: begin
        c.hub_mode = RH_SUSPENDED;
        do_link    = 1'b1;
      end
      OP_BUS_RESUME: begin
        if (!c.hw_accessible) begin
          err = ERR_SHUTDOWN;
        end else begin
          c.hub_mode = RH_RUNNING;
          do_link    = 1'b1;
        end
      end
      OP_STOP: begin
        c.hw_accessible    = 1'b0;
        c.conn_timer_armed = 1'b0;
      end
      OP_PLAT_RESUME: begin
        c.hw_accessible = 1'b1;
      end
      OP_PLAT_SUSPEND: begin
        if (c.hub_mode == RH_RUNNING) begin
          err = ERR_BUSY;
        end else begin
          c.hw_accessible = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (do_link) begin
      lr = update_link(c, item.kick_refused);
      c  = lr.ctl;
      if (lr.arm) begin
        conn_deadline_nxt  = later_gadget;
        c.conn_timer_armed = 1'b1;
      end
    end

    if (op_e == OP_STATUS_POLL && c.hw_accessible && (c.stat_word & CH_MASK) != '0 &&
        c.hub_mode == RH_SUSPENDED) begin
      resume_req = 1'b1;
    end

    ctl_nxt                        = c;
    result.status_word             = c.stat_word;
    result.error                   = err;
    result.change_pending          = (c.stat_word & CH_MASK) != '0;
    result.gadget_reset_kick       = lr.kick;
    result.root_hub_resume_request = resume_req;
  end

endmodule

### rtl/usb_root_hub_port_status.sv
// ----------------------------------------------------------------------------
// usb_root_hub_port_status
// Emulated USB 2.0 root-hub port: status word, port features and timers.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while ready is high and registers its result
// in the output register, or in the one-entry skid register behind it while
// the output holds an untaken result; ready drops only when both hold one.
// The port state, tick counter and both deadlines update in the cycle of
// acceptance, so consecutive items see each other's effects with no gap. The
// user must write tick registers through the cfg_ port only while the block
// is idle; the block does not enforce this. A tick count of zero makes its
// deadline expire at once. Time values are TIME_BITS wide and wrap.
// ----------------------------------------------------------------------------
module usb_root_hub_port_status
  import urh_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  urh_in_if.sink               in_ch,
  urh_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  localparam urh_ctl_t CTL_RESET = '{
    stat_word:        '0,
    previous_status:  '0,
    link_active:      1'b0,
    resuming:         1'b0,
    hub_mode:         RH_RESET,
    hw_accessible:    1'b1,
    conn_timer_armed: 1'b0
  };

  logic [TICK_W-1:0]    reset_ticks_r;
  logic [TICK_W-1:0]    resume_ticks_r;
  logic [TICK_W-1:0]    gadget_wait_r;

  urh_ctl_t             ctl_r, ctl_nxt;
  logic [TIME_BITS-1:0] deadline_r, deadline_nxt;
  logic [TIME_BITS-1:0] time_now_r, time_now_nxt;
  logic [TIME_BITS-1:0] conn_deadline_r, conn_deadline_nxt;

  urh_item_t            item;
  urh_result_t          result;
  urh_result_t          out_data_r, skid_data_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 in_acc, out_acc;

  assign item.op           = in_ch.op;
  assign item.req_kind     = in_ch.req_kind;
  assign item.feature      = in_ch.feature;
  assign item.port_number  = in_ch.port_number;
  assign item.kick_refused = in_ch.kick_refused;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;

  urh_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .item              (item),
    .ctl               (ctl_r),
    .deadline          (deadline_r),
    .time_now          (time_now_r),
    .conn_deadline     (conn_deadline_r),
    .reset_ticks       (reset_ticks_r),
    .resume_ticks      (resume_ticks_r),
    .gadget_wait_ticks (gadget_wait_r),
    .ctl_nxt           (ctl_nxt),
    .deadline_nxt      (deadline_nxt),
    .time_now_nxt      (time_now_nxt),
    .conn_deadline_nxt (conn_deadline_nxt),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_ticks_r  <= RESET_TICKS_DEF;
      resume_ticks_r <= RESUME_TICKS_DEF;
      gadget_wait_r  <= GADGET_WAIT_DEF;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RESET_TICKS) begin
        reset_ticks_r <= cfg_wdata;
      end
      if (cfg_index == CFG_RESUME_TICKS) begin
        resume_ticks_r <= cfg_wdata;
      end
      if (cfg_index == CFG_GADGET_WAIT) begin
        gadget_wait_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r           <= CTL_RESET;
      deadline_r      <= '0;
      time_now_r      <= '0;
      conn_deadline_r <= '0;
    end else if (in_acc) begin
      ctl_r           <= ctl_nxt;
      deadline_r      <= deadline_nxt;
      time_now_r      <= time_now_nxt;
      conn_deadline_r <= conn_deadline_nxt;
    end
  end

  // Output register with skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        out_valid_r  <= skid_valid_r || in_acc;
        skid_valid_r <= 1'b0;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (in_acc && out_valid_r && !out_acc) begin
      skid_data_r <= result;
    end
  end

  assign out_ch.valid                   = out_valid_r;
  assign out_ch.status_word             = out_data_r.status_word;
  assign out_ch.error                   = out_data_r.error;
  assign out_ch.change_pending          = out_data_r.change_pending;
  assign out_ch.gadget_reset_kick       = out_data_r.gadget_reset_kick;
  assign out_ch.root_hub_resume_request = out_data_r.root_hub_resume_request;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.change_pending == ((out_data_r.status_word & CH_MASK) != '0)))
    else $error("change_pending disagrees with status word");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> ($stable(ctl_r) && $stable(time_now_r)))
    else $error("port state moved without an accepted item");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the emulated USB 2.0 root-hub port.
// Sends hub requests, ticks and bus/platform events through the input channel
// and checks every result beat against an in-bench model of the port status
// word, the reset and resume deadlines and the gadget connection timer. A
// directed part covers the request kinds, power, reset handshakes, suspend and
// resume, and hardware access. A random part covers port sessions and noise
// under several timer settings and four patterns of source and sink idling.
// ----------------------------------------------------------------------------
module testbench;
  import urh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0]  FEAT_ENABLE        = 5'd1;
  localparam logic [4:0]  FEAT_C_CONNECTION  = 5'd16;
  localparam logic [4:0]  FEAT_TOP           = 5'd31;
  localparam logic [3:0]  REQ_UNDEFINED      = 4'd15;
  localparam logic [3:0]  OP_UNDEFINED       = 4'd15;
  localparam logic [15:0] PORT_TOP           = 16'hFFFF;
  localparam logic [15:0] PORT_NONE          = 16'd0;
  localparam int          WATCHDOG_LIMIT     = 2000;
  localparam int          REPORT_LIMIT       = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0] cfg_wdata;

  urh_in_if  in_ch();
  urh_out_if out_ch();

  usb_root_hub_port_status uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // port model state
  logic [31:0]       port_word;
  logic [31:0]       last_word;
  logic              link_up;
  logic              resume_active;
  logic [31:0]       finish_time;
  logic [31:0]       now_ticks;
  urh_rh_t           hub_state;
  logic              hw_on;
  logic              wait_armed;
  logic [31:0]       wait_deadline;
  logic              kick_seen;
  logic [TICK_W-1:0] reset_wait;
  logic [TICK_W-1:0] resume_wait;
  logic [TICK_W-1:0] gadget_wait;

  urh_result_t replies_due[$];

  int src_gap_pct;
  int snk_stall_pct;
  int items_sent;
  int results_checked;
  int mismatches;
  int cfg_writes;
  int kicks_due;
  int wakes_due;

  function automatic logic time_reached(input logic [31:0] when);
    logic [31:0] diff;
    diff = now_ticks - when;
    return !diff[31];
  endfunction

  function automatic void refresh_link(input logic refused);
    link_up = 1'b0;
    if ((port_word & ST_POWER) == '0) begin
      port_word = '0;
    end else begin
      port_word |= ST_CONN;
      if ((last_word & ST_CONN) == '0) port_word |= CH_CONN;
      if ((port_word & ST_ENABLE) == '0) begin
        port_word &= ~ST_SUSP;
      end else if ((port_word & ST_SUSP) == '0 && hub_state != RH_SUSPENDED) begin
        link_up = 1'b1;
      end
    end
    if ((port_word & ST_ENABLE) == '0 || link_up) resume_active = 1'b0;
    if ((port_word & ST_CONN) == '0 || (port_word & ST_RESET) != '0) begin
      if ((ST_RESET & ~last_word & port_word) != '0) begin
        port_word |= ST_POWER;
        kick_seen = 1'b1;
        if (!refused) begin
          wait_deadline = now_ticks + gadget_wait;
          wait_armed    = 1'b1;
        end else begin
          port_word = CH_CONN;
        end
      end
    end
    last_word = port_word;
  endfunction

  function automatic urh_err_t serve_request(input urh_item_t it);
    urh_err_t    err;
    logic [31:0] bit_sel;
    err     = ERR_OK;
    bit_sel = 32'd1 << it.feature;
    if (!hw_on) return ERR_NOACCESS;
    case (it.req_kind)
      REQ_CLR_HUB_FEAT, REQ_GET_HUB_DESC, REQ_GET_HUB_STAT, REQ_GET_ERR_COUNT,
      REQ_SET_HUB_DEPTH: ;
      REQ_CLR_PORT_FEAT: begin
        if (it.feature == FEAT_SUSPEND) begin
          if ((port_word & ST_SUSP) != '0) begin
            resume_active = 1'b1;
            finish_time   = now_ticks + resume_wait;
          end
        end else begin
          port_word &= ~bit_sel;
          refresh_link(it.kick_refused);
        end
      end
      REQ_GET_PORT_STAT: begin
        if (it.port_number != ROOT_PORT) err = ERR_STALL;
        if (resume_active && time_reached(finish_time)) begin
          port_word |= CH_SUSP;
          port_word &= ~ST_SUSP;
        end
        if ((port_word & ST_RESET) != '0 && time_reached(finish_time)) begin
          port_word |= CH_RESET;
          port_word &= ~ST_RESET;
          port_word |= ST_ENABLE | ST_HIGH;
        end
        refresh_link(it.kick_refused);
      end
      REQ_SET_PORT_FEAT: begin
        if (it.feature == FEAT_LINK_STATE || it.feature == FEAT_U1_TIMEOUT ||
            it.feature == FEAT_U2_TIMEOUT) begin
        end else if (it.feature == FEAT_SUSPEND) begin
          if (link_up) begin
            port_word |= ST_SUSP;
            refresh_link(it.kick_refused);
          end
        end else if (it.feature == FEAT_POWER) begin
          port_word |= ST_POWER;
          refresh_link(it.kick_refused);
        end else begin
          if (it.feature == FEAT_RESET || it.feature == FEAT_BH_RESET) begin
            port_word &= ~(ST_ENABLE | ST_LOW | ST_HIGH);
            finish_time = now_ticks + reset_wait;
          end
          if ((port_word & ST_POWER) != '0) begin
            port_word |= bit_sel;
            refresh_link(it.kick_refused);
          end
        end
      end
      default: err = ERR_STALL;
    endcase
    return err;
  endfunction

  function automatic urh_result_t predict_port(input urh_item_t it);
    urh_result_t r;
    urh_err_t    err;
    logic        wake;
    err       = ERR_OK;
    wake      = 1'b0;
    kick_seen = 1'b0;
    case (it.op)
      OP_TICK: begin
        now_ticks = now_ticks + 32'd1;
        if (wait_armed && time_reached(wait_deadline)) begin
          wait_armed = 1'b0;
          port_word  = CH_CONN;
        end
      end
      OP_HUB_REQ: err = serve_request(it);
      OP_STATUS_POLL: begin
        if (hw_on) begin
          if (resume_active && time_reached(finish_time)) begin
            port_word |= CH_SUSP;
            port_word &= ~ST_SUSP;
            refresh_link(it.kick_refused);
          end
          if ((port_word & CH_MASK) != '0 && hub_state == RH_SUSPENDED) wake = 1'b1;
        end
      end
      OP_GADGET_DONE: wait_armed = 1'b0;
      OP_BUS_SUSPEND: begin
        hub_state = RH_SUSPENDED;
        refresh_link(it.kick_refused);
      end
      OP_BUS_RESUME: begin
        if (!hw_on) begin
          err = ERR_SHUTDOWN;
        end else begin
          hub_state = RH_RUNNING;
          refresh_link(it.kick_refused);
        end
      end
      OP_STOP: begin
        hw_on      = 1'b0;
        wait_armed = 1'b0;
      end
      OP_PLAT_RESUME: hw_on = 1'b1;
      OP_PLAT_SUSPEND: begin
        if (hub_state == RH_RUNNING) err = ERR_BUSY;
        else hw_on = 1'b0;
      end
      default: ;
    endcase
    r.status_word             = port_word;
    r.error                   = err;
    r.change_pending          = |(port_word & CH_MASK);
    r.gadget_reset_kick       = kick_seen;
    r.root_hub_resume_request = wake;
    return r;
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
  endfunction

  // result checker
  always @(posedge clk) begin
    urh_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        note_mismatch("unexpected beat, status_word", '0, out_ch.status_word);
      end else begin
        want = replies_due.pop_front();
        results_checked++;
        if (out_ch.status_word !== want.status_word)
          note_mismatch("status_word", want.status_word, out_ch.status_word);
        if (out_ch.error !== want.error)
          note_mismatch("error", 32'(want.error), 32'(out_ch.error));
        if (out_ch.change_pending !== want.change_pending)
          note_mismatch("change_pending", 32'(want.change_pending),
                        32'(out_ch.change_pending));
        if (out_ch.gadget_reset_kick !== want.gadget_reset_kick)
          note_mismatch("gadget_reset_kick", 32'(want.gadget_reset_kick),
                        32'(out_ch.gadget_reset_kick));
        if (out_ch.root_hub_resume_request !== want.root_hub_resume_request)
          note_mismatch("root_hub_resume_request", 32'(want.root_hub_resume_request),
                        32'(out_ch.root_hub_resume_request));
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("** usb_root_hub_port_status: FAILED **");
    $finish;
  end

  task automatic send_item(input urh_item_t it);
    urh_result_t r;
    while ($urandom_range(99) < src_gap_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.op           <= it.op;
    in_ch.req_kind     <= it.req_kind;
    in_ch.feature      <= it.feature;
    in_ch.port_number  <= it.port_number;
    in_ch.kick_refused <= it.kick_refused;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    r = predict_port(it);
    replies_due.push_back(r);
    items_sent++;
    if (r.gadget_reset_kick) kicks_due++;
    if (r.root_hub_resume_request) wakes_due++;
  endtask

  function automatic urh_item_t random_item();
    urh_item_t it;
    int        pick;
    it.req_kind     = 4'($urandom_range(15));
    it.feature      = 5'($urandom_range(31));
    it.port_number  = 16'($urandom_range(65535));
    it.kick_refused = ($urandom_range(5) == 0);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.op = OP_TICK;
    end else if (pick < 65) begin
      it.op = OP_HUB_REQ;
      if ($urandom_range(99) < 85) it.port_number = ROOT_PORT;
      case ($urandom_range(9))
        0, 1, 2: it.req_kind = REQ_SET_PORT_FEAT;
        3, 4:    it.req_kind = REQ_GET_PORT_STAT;
        5, 6:    it.req_kind = REQ_CLR_PORT_FEAT;
        default: ;
      endcase
      case ($urandom_range(9))
        0: it.feature = FEAT_SUSPEND;
        1: it.feature = FEAT_RESET;
        2: it.feature = FEAT_POWER;
        3: it.feature = FEAT_ENABLE;
        4: it.feature = 5'(FEAT_C_CONNECTION + $urandom_range(4));
        5: it.feature = FEAT_BH_RESET;
        6: it.feature = FEAT_LINK_STATE;
        default: ;
      endcase
    end else if (pick < 75) begin
      it.op = OP_STATUS_POLL;
    end else if (pick < 80) begin
      it.op = OP_GADGET_DONE;
    end else if (pick < 85) begin
      it.op = OP_BUS_SUSPEND;
    end else if (pick < 91) begin
      it.op = OP_BUS_RESUME;
    end else if (pick < 94) begin
      it.op = OP_PLAT_RESUME;
    end else begin
      it.op = 4'($urandom_range(OP_UNDEFINED, OP_STOP));
    end
    return it;
  endfunction

  task automatic event_op(input logic [3:0] op);
    urh_item_t it;
    it              = random_item();
    it.op           = op;
    it.kick_refused = ($urandom_range(7) == 0);
    send_item(it);
  endtask

  task automatic port_request(input logic [3:0] kind, input logic [4:0] feat,
                              input logic [15:0] port, input logic refused);
    urh_item_t it;
    it.op           = OP_HUB_REQ;
    it.req_kind     = kind;
    it.feature      = feat;
    it.port_number  = port;
    it.kick_refused = refused;
    send_item(it);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input urh_cfg_idx_t idx, input logic [TICK_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_RESET_TICKS:  reset_wait  = val;
      CFG_RESUME_TICKS: resume_wait = val;
      CFG_GADGET_WAIT:  gadget_wait = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic load_timers(input logic [TICK_W-1:0] rst_ticks,
                             input logic [TICK_W-1:0] rsm_ticks,
                             input logic [TICK_W-1:0] gdg_ticks);
    hold_until_drained();
    write_reg(CFG_RESET_TICKS, rst_ticks);
    write_reg(CFG_RESUME_TICKS, rsm_ticks);
    write_reg(CFG_GADGET_WAIT, gdg_ticks);
  endtask

  task automatic test_hub_requests();
    port_request(REQ_DEV_GET_DESC, FEAT_TOP, PORT_TOP, 1'b1);
    port_request(REQ_SET_HUB_FEAT, FEAT_POWER, ROOT_PORT, 1'b0);
    port_request(REQ_UNDEFINED, FEAT_RESET, ROOT_PORT, 1'b0);
  endtask

  task automatic test_port_power();
    port_request(REQ_SET_PORT_FEAT, FEAT_BH_RESET, ROOT_PORT, 1'b0);
    port_request(REQ_SET_PORT_FEAT, FEAT_LINK_STATE, PORT_NONE, 1'b0);
    port_request(REQ_SET_PORT_FEAT, FEAT_POWER, ROOT_PORT, 1'b0);
    port_request(REQ_CLR_PORT_FEAT, FEAT_TOP, PORT_TOP, 1'b1);
  endtask

  task automatic test_reset_handshake();
    port_request(REQ_SET_PORT_FEAT, FEAT_RESET, ROOT_PORT, 1'b1);
    port_request(REQ_SET_PORT_FEAT, FEAT_POWER, ROOT_PORT, 1'b0);
    port_request(REQ_SET_PORT_FEAT, FEAT_RESET, ROOT_PORT, 1'b0);
    port_request(REQ_GET_PORT_STAT, FEAT_TOP, ROOT_PORT, 1'b0);
    port_request(REQ_SET_PORT_FEAT, FEAT_RESET, ROOT_PORT, 1'b0);
    port_request(REQ_GET_PORT_STAT, FEAT_SUSPEND, PORT_NONE, 1'b0);
    event_op(OP_GADGET_DONE);
  endtask

  task automatic test_suspend_resume();
    event_op(OP_BUS_RESUME);
    port_request(REQ_SET_PORT_FEAT, FEAT_SUSPEND, ROOT_PORT, 1'b0);
    event_op(OP_BUS_SUSPEND);
    port_request(REQ_CLR_PORT_FEAT, FEAT_SUSPEND, ROOT_PORT, 1'b0);
    event_op(OP_STATUS_POLL);
    port_request(REQ_CLR_PORT_FEAT, FEAT_C_CONNECTION, ROOT_PORT, 1'b0);
  endtask

  task automatic test_access_control();
    port_request(REQ_SET_PORT_FEAT, FEAT_RESET, ROOT_PORT, 1'b0);
    event_op(OP_BUS_SUSPEND);
    event_op(OP_PLAT_SUSPEND);
    port_request(REQ_GET_PORT_STAT, FEAT_RESET, ROOT_PORT, 1'b0);
    event_op(OP_BUS_RESUME);
    repeat (3) event_op(OP_TICK);
    event_op(OP_PLAT_RESUME);
    event_op(OP_BUS_RESUME);
    event_op(OP_PLAT_SUSPEND);
    event_op(OP_STOP);
    event_op(OP_UNDEFINED);
  endtask

  task automatic run_port_session();
    int        reset_span;
    int        resume_span;
    urh_item_t noise;
    reset_span  = (reset_wait > 12) ? 12 : reset_wait;
    resume_span = (resume_wait > 12) ? 12 : resume_wait;
    noise       = random_item();
    if (!hw_on && $urandom_range(3) != 0) event_op(OP_PLAT_RESUME);
    if ($urandom_range(3) == 0) event_op(OP_BUS_RESUME);
    port_request(REQ_SET_PORT_FEAT, FEAT_POWER, ROOT_PORT, 1'b0);
    port_request(REQ_SET_PORT_FEAT, ($urandom_range(4) == 0) ? FEAT_BH_RESET : FEAT_RESET,
                 ROOT_PORT, $urandom_range(9) == 0);
    repeat ($urandom_range(reset_span + 1)) event_op(OP_TICK);
    port_request(REQ_GET_PORT_STAT, noise.feature,
                 ($urandom_range(9) == 0) ? noise.port_number : ROOT_PORT, 1'b0);
    if ($urandom_range(3) != 0) event_op(OP_GADGET_DONE);
    if ($urandom_range(1) != 0) event_op(OP_BUS_RESUME);
    port_request(REQ_SET_PORT_FEAT, FEAT_SUSPEND, ROOT_PORT, 1'b0);
    if ($urandom_range(1) != 0) event_op(OP_BUS_SUSPEND);
    port_request(REQ_CLR_PORT_FEAT, FEAT_SUSPEND, ROOT_PORT, 1'b0);
    repeat ($urandom_range(resume_span + 1)) event_op(OP_TICK);
    if ($urandom_range(1) != 0) event_op(OP_STATUS_POLL);
    else port_request(REQ_GET_PORT_STAT, FEAT_SUSPEND, ROOT_PORT, 1'b0);
    if ($urandom_range(1) != 0)
      port_request(REQ_CLR_PORT_FEAT, 5'(FEAT_C_CONNECTION + $urandom_range(4)),
                   ROOT_PORT, 1'b0);
  endtask

  task automatic test_random_traffic();
    int   phase;
    int   target;
    logic paused;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_timers(16'd2, 16'd2, 16'd20);
        1: load_timers(16'd1, 16'd1, 16'd1);
        2: load_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: load_timers(16'd0, 16'd3, 16'd8);
        6: load_timers(16'($urandom_range(6)), 16'($urandom_range(6)), 16'hFFFF);
        default: load_timers(16'($urandom_range(6)), 16'($urandom_range(6)),
                             16'($urandom_range(60, 3)));
      endcase
      case (phase % 4)
        0: begin src_gap_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_gap_pct = 69; snk_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  snk_stall_pct = 69; end
        default: begin src_gap_pct = 25; snk_stall_pct = 25; end
      endcase
      target = items_sent + 205;
      paused = 1'b0;
      while (items_sent < target) begin
        if (!paused && items_sent >= target - 100) begin
          hold_until_drained();
          paused = 1'b1;
        end
        if ($urandom_range(2) != 0) run_port_session();
        else repeat (8) send_item(random_item());
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_RESET_TICKS;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_TICK;
    in_ch.req_kind     = REQ_CLR_HUB_FEAT;
    in_ch.feature      = '0;
    in_ch.port_number  = '0;
    in_ch.kick_refused = 1'b0;
    out_ch.ready       = 1'b0;
    port_word          = '0;
    last_word          = '0;
    link_up            = 1'b0;
    resume_active      = 1'b0;
    finish_time        = '0;
    now_ticks          = '0;
    hub_state          = RH_RESET;
    hw_on              = 1'b1;
    wait_armed         = 1'b0;
    wait_deadline      = '0;
    kick_seen          = 1'b0;
    reset_wait         = RESET_TICKS_DEF;
    resume_wait        = RESUME_TICKS_DEF;
    gadget_wait        = GADGET_WAIT_DEF;
    src_gap_pct        = 0;
    snk_stall_pct      = 0;
    items_sent         = 0;
    results_checked    = 0;
    mismatches         = 0;
    cfg_writes         = 0;
    kicks_due          = 0;
    wakes_due          = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_timers(16'd0, 16'd0, 16'd3);
    test_hub_requests();
    test_port_power();
    test_reset_handshake();
    test_suspend_resume();
    test_access_control();
    test_random_traffic();

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (replies_due.size() != 0) begin
      $display("%0d expected results never arrived", replies_due.size());
      mismatches += replies_due.size();
    end
    $display("Sent %0d requests and events over 8 timer settings and 4 idling patterns,",
             items_sent);
    $display("%0d results checked, %0d register writes, %0d reset kicks, %0d resume requests",
             results_checked, cfg_writes, kicks_due, wakes_due);
    if (mismatches == 0) begin
      $display("** usb_root_hub_port_status: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** usb_root_hub_port_status: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/urh_pkg.sv
rtl/urh_in_if.sv
rtl/urh_out_if.sv
rtl/urh_step.sv
rtl/usb_root_hub_port_status.sv
verif/testbench.sv
